[rtl/pced_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Percent codec package
// Shared constants, the job record passed from front end to back end, and
// the character classification helpers.
// ----------------------------------------------------------------------------
package pced_pkg;

   localparam logic [7:0] PCT_CHAR   = 8'd37;
   localparam logic [7:0] DIGIT_LO   = 8'd48;
   localparam logic [7:0] DIGIT_HI   = 8'd57;
   localparam logic [7:0] UPPER_LO   = 8'd65;
   localparam logic [7:0] UPPER_HI   = 8'd90;
   localparam logic [7:0] LOWER_LO   = 8'd97;
   localparam logic [7:0] LOWER_HI   = 8'd122;
   localparam logic [7:0] UPPER_F    = 8'd70;
   localparam logic [7:0] LOWER_F    = 8'd102;
   localparam logic [7:0] TILDE_CHAR = 8'd126;
   localparam logic [7:0] DASH_CHAR  = 8'd45;
   localparam logic [7:0] UNDER_CHAR = 8'd95;
   localparam logic [7:0] DOT_CHAR   = 8'd46;

   localparam logic DIR_ENCODE = 1'b0;
   localparam logic DIR_DECODE = 1'b1;

   localparam logic [1:0] HELD_NONE  = 2'd0;
   localparam logic [1:0] HELD_PCT   = 2'd1;
   localparam logic [1:0] HELD_DIGIT = 2'd2;

   localparam int JOB_BYTES = 3;

   typedef struct packed {
      logic [JOB_BYTES-1:0][7:0] bytes;
      logic [1:0]                cnt;
      logic                      last;
   } job_type;

   function automatic logic is_unreserved(input logic [7:0] b);
      return (b >= DIGIT_LO && b <= DIGIT_HI) || (b >= UPPER_LO && b <= UPPER_HI) ||
             (b >= LOWER_LO && b <= LOWER_HI) || b == TILDE_CHAR || b == DASH_CHAR ||
             b == UNDER_CHAR || b == DOT_CHAR;
   endfunction

   function automatic logic is_hex(input logic [7:0] b);
      return (b >= DIGIT_LO && b <= DIGIT_HI) || (b >= UPPER_LO && b <= UPPER_F) ||
             (b >= LOWER_LO && b <= LOWER_F);
   endfunction

   function automatic logic [3:0] hex_value(input logic [7:0] b);
      logic [7:0] v;
      if (b >= DIGIT_LO && b <= DIGIT_HI) begin
         v = b - DIGIT_LO;
      end else if (b >= UPPER_LO && b <= UPPER_F) begin
         v = b - 8'd55;
      end else begin
         v = b - 8'd87;
      end
      return v[3:0];
   endfunction

   function automatic logic [7:0] hex_char(input logic [3:0] nib);
      return (nib <= 4'd9) ? ({4'd0, nib} + DIGIT_LO) : ({4'd0, nib} + 8'd55);
   endfunction

endpackage

[rtl/pced_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Percent codec front end
// Accepts requests, classifies each byte, tracks a pending escape and builds
// a job of up to three output bytes.
// ----------------------------------------------------------------------------
module pced_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_wr_en,
   input  logic              csr_wr_data,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [7:0]        req_tdata,
   input  logic              req_tlast,
   input  logic              job_full,
   output logic              job_push,
   output pced_pkg::job_type job_out
);

   logic       direction_ff, direction_in;
   logic [1:0] held_ff, held_in;
   logic [7:0] digit_ff, digit_in;
   logic       accept;

   pced_pkg::job_type job;
   logic [1:0]        n;
   logic [1:0]        held_nx;

   assign req_tready = !job_full;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      job       = '0;
      n         = 2'd0;
      held_nx   = held_ff;
      digit_in  = digit_ff;
      if (direction_ff == pced_pkg::DIR_ENCODE) begin
         held_nx = pced_pkg::HELD_NONE;
         if (pced_pkg::is_unreserved(req_tdata)) begin
            job.bytes[0] = req_tdata;
            n = 2'd1;
         end else begin
            job.bytes[0] = pced_pkg::PCT_CHAR;
            job.bytes[1] = pced_pkg::hex_char(req_tdata[7:4]);
            job.bytes[2] = pced_pkg::hex_char(req_tdata[3:0]);
            n = 2'd3;
         end
      end else begin
         unique case (held_ff)
            pced_pkg::HELD_PCT: begin
               if (pced_pkg::is_hex(req_tdata)) begin
                  digit_in = req_tdata;
                  held_nx  = pced_pkg::HELD_DIGIT;
               end else begin
                  job.bytes[0] = pced_pkg::PCT_CHAR;
                  n = 2'd1;
                  if (req_tdata == pced_pkg::PCT_CHAR) begin
                     held_nx = pced_pkg::HELD_PCT;
                  end else begin
                     held_nx = pced_pkg::HELD_NONE;
                     job.bytes[1] = req_tdata;
                     n = 2'd2;
                  end
               end
            end
            pced_pkg::HELD_DIGIT: begin
               if (pced_pkg::is_hex(req_tdata)) begin
                  job.bytes[0] = {pced_pkg::hex_value(digit_ff),
                                  pced_pkg::hex_value(req_tdata)};
                  n = 2'd1;
                  held_nx = pced_pkg::HELD_NONE;
               end else begin
                  job.bytes[0] = pced_pkg::PCT_CHAR;
                  job.bytes[1] = digit_ff;
                  n = 2'd2;
                  if (req_tdata == pced_pkg::PCT_CHAR) begin
                     held_nx = pced_pkg::HELD_PCT;
                  end else begin
                     held_nx = pced_pkg::HELD_NONE;
                     job.bytes[2] = req_tdata;
                     n = 2'd3;
                  end
               end
            end
            default: begin
               if (req_tdata == pced_pkg::PCT_CHAR) begin
                  held_nx = pced_pkg::HELD_PCT;
               end else begin
                  held_nx = pced_pkg::HELD_NONE;
                  job.bytes[0] = req_tdata;
                  n = 2'd1;
               end
            end
         endcase
         if (req_tlast) begin
            if (held_nx != pced_pkg::HELD_NONE && n != 2'd3) begin
               job.bytes[n] = pced_pkg::PCT_CHAR;
               n = n + 2'd1;
            end
            if (held_nx == pced_pkg::HELD_DIGIT && n != 2'd3) begin
               job.bytes[n] = digit_in;
               n = n + 2'd1;
            end
            held_nx = pced_pkg::HELD_NONE;
         end
      end
      job.cnt  = n;
      job.last = req_tlast;
   end

   assign job_out  = job;
   assign job_push = accept && (n != 2'd0);

   always_comb begin
      direction_in = direction_ff;
      held_in      = held_ff;
      if (csr_wr_en) begin
         direction_in = csr_wr_data;
         held_in      = pced_pkg::HELD_NONE;
      end else if (accept) begin
         held_in = held_nx;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         direction_ff <= pced_pkg::DIR_ENCODE;
         held_ff      <= pced_pkg::HELD_NONE;
         digit_ff     <= 8'd0;
      end else begin
         direction_ff <= direction_in;
         held_ff      <= held_in;
         if (accept && !csr_wr_en) begin
            digit_ff <= digit_in;
         end
      end
   end

endmodule

[rtl/pced_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Percent codec job queue
// Two-entry queue of jobs between the front end and the back end.
// ----------------------------------------------------------------------------
module pced_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  pced_pkg::job_type push_job,
   output logic              full,
   input  logic              pop,
   output logic              head_valid,
   output pced_pkg::job_type head_job
);

   pced_pkg::job_type entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_pop;

   assign full       = (count_ff == 2'd2);
   assign head_valid = (count_ff != 2'd0);
   assign head_job   = entry_ff[rd_ptr_ff];
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !do_pop) begin
         count_in = count_ff + 2'd1;
      end else if (do_pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

[rtl/pced_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Percent codec back end
// Takes jobs from the queue and sends their bytes one at a time through a
// registered output stage.
// ----------------------------------------------------------------------------
module pced_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              head_valid,
   input  pced_pkg::job_type head_job,
   output logic              pop,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [7:0]        rsp_tdata,
   output logic              rsp_tlast,
   output logic              rsp_tuser
);

   pced_pkg::job_type job_ff, job_in;
   logic       busy_ff, busy_in;
   logic [1:0] pos_ff, pos_in;
   logic       valid_ff, valid_in;
   logic [7:0] data_ff, data_in;
   logic       tlast_ff, tlast_in;
   logic       tuser_ff, tuser_in;
   logic       out_free;
   logic       final_byte;

   assign out_free   = !valid_ff || rsp_tready;
   assign final_byte = (pos_ff == job_ff.cnt - 2'd1);
   assign pop        = head_valid && (!busy_ff || (out_free && final_byte));

   always_comb begin
      job_in   = job_ff;
      busy_in  = busy_ff;
      pos_in   = pos_ff;
      valid_in = valid_ff && !rsp_tready;
      data_in  = data_ff;
      tlast_in = tlast_ff;
      tuser_in = tuser_ff;
      if (busy_ff && out_free) begin
         valid_in = 1'b1;
         data_in  = job_ff.bytes[pos_ff];
         tlast_in = final_byte;
         tuser_in = final_byte && job_ff.last;
         pos_in   = pos_ff + 2'd1;
         if (final_byte) begin
            busy_in = 1'b0;
         end
      end
      if (pop) begin
         job_in  = head_job;
         busy_in = 1'b1;
         pos_in  = 2'd0;
      end
   end

   always_ff @(posedge clock) begin
      job_ff   <= job_in;
      pos_ff   <= pos_in;
      data_ff  <= data_in;
      tlast_ff <= tlast_in;
      tuser_ff <= tuser_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         busy_ff  <= busy_in;
         valid_ff <= valid_in;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;
   assign rsp_tlast  = tlast_ff;
   assign rsp_tuser  = tuser_ff;

endmodule

[rtl/percent_encode_decode_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Percent codec core
// URL percent encoder and decoder for a byte stream.
// ----------------------------------------------------------------------------
// The block takes one request per clock while the job queue has room and
// sends one result byte per clock while the output is not stalled. A request
// that expands to two or three bytes holds the output port until all of them
// are sent, since the output register moves a single byte per cycle, and a
// two-entry job queue between the classifier and the output sequencer absorbs
// the difference. The user must set the direction through csr_wr_en and
// csr_wr_data only while the stream is idle; the block does not enforce this.
// A write also drops any partly received escape. rsp_tlast marks the last byte
// caused by a request and rsp_tuser the final byte of a string.
module percent_encode_decode_core (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_wr_en,
   input  logic       csr_wr_data,   // direction: 0 encode, 1 decode
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,     // [7:0] in_byte
   input  logic       req_tlast,     // in_last
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,     // [7:0] out_byte
   output logic       rsp_tlast,     // run_last
   output logic       rsp_tuser      // [0] string_end
);

   pced_pkg::job_type push_job;
   pced_pkg::job_type head_job;
   logic              job_push;
   logic              job_full;
   logic              job_pop;
   logic              head_valid;

   pced_front u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .job_full    (job_full),
      .job_push    (job_push),
      .job_out     (push_job)
   );

   pced_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (job_push),
      .push_job   (push_job),
      .full       (job_full),
      .pop        (job_pop),
      .head_valid (head_valid),
      .head_job   (head_job)
   );

   pced_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_job   (head_job),
      .pop        (job_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

[rtl/pced_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Percent codec port checker
// Checks the behavior visible at the ports of the core.
// ----------------------------------------------------------------------------
module pced_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_tready,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata,
   input logic       rsp_tlast,
   input logic       rsp_tuser
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) &&
      $stable(rsp_tlast) && $stable(rsp_tuser))
      else $error("stalled result changed");

   a_end_is_run_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tlast)
      else $error("string end without run last");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   a_reset_ready: assert property (@(posedge clock)
      reset |=> req_tready)
      else $error("request not ready right after reset");

endmodule

bind percent_encode_decode_core pced_checker u_pced_checker (.*);

[tb/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Percent codec core testbench
// Streams bytes through the URL percent encoder and decoder, first from a
// short table of edge cases, then in random phases that switch the
// direction and throttle either side of the stream. Every result byte is
// compared with a byte-level prediction of the codec.
// ----------------------------------------------------------------------------
module tb;

   localparam int DRAIN_CYCLES    = 16;
   localparam int STALL_LIMIT     = 2000;
   localparam int PHASES          = 8;
   localparam int ITEMS_PER_PHASE = 40;
   localparam int PRESSURE_PHASE  = 4;

   localparam logic PHASE_DIR [PHASES] = '{pced_pkg::DIR_ENCODE, pced_pkg::DIR_DECODE,
                                           pced_pkg::DIR_DECODE, pced_pkg::DIR_ENCODE,
                                           pced_pkg::DIR_DECODE, pced_pkg::DIR_ENCODE,
                                           pced_pkg::DIR_DECODE, pced_pkg::DIR_DECODE};
   localparam int PHASE_SEND_IDLE [PHASES] = '{0, 55, 0, 19, 0, 55, 0, 19};
   localparam int PHASE_RSP_STALL [PHASES] = '{0, 0, 55, 19, 0, 0, 55, 19};

   typedef struct packed {
      logic [7:0] data;
      logic       run_last;
      logic       string_end;
   } out_byte_type;

   typedef enum logic {ROW_REQ, ROW_CSR} row_kind_type;

   typedef struct packed {
      row_kind_type    kind;
      logic [7:0]      data;
      logic            last;
      logic [1:0]      known_n;
      logic [2:0][7:0] known;
   } stim_row_type;

   logic         clock = 1'b0;
   logic         reset;
   logic         csr_wr_en;
   logic         csr_wr_data;
   logic         req_tvalid;
   logic         req_tready;
   logic [7:0]   req_tdata;
   logic         req_tlast;
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [7:0]   rsp_tdata;
   logic         rsp_tlast;
   logic         rsp_tuser;

   logic         codec_dir;
   logic [1:0]   held_count;
   logic [7:0]   held_digit;
   logic [7:0]   step_bytes[$];
   out_byte_type awaited_bytes[$];
   logic [7:0]   fragment_q[$];
   stim_row_type stim_rows[$];
   out_byte_type head;
   int           mismatch_count = 0;
   int           quiet_cycles = 0;
   int           send_idle_pct = 0;
   int           rsp_stall_pct = 0;

   percent_encode_decode_core dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .rsp_tuser   (rsp_tuser)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic url_safe(input logic [7:0] b);
      return (b inside {["0":"9"], ["A":"Z"], ["a":"z"]}) || b == "~" || b == "-" ||
             b == "_" || b == ".";
   endfunction

   function automatic logic hex_ok(input logic [7:0] b);
      return b inside {["0":"9"], ["A":"F"], ["a":"f"]};
   endfunction

   function automatic logic [3:0] hex_nibble(input logic [7:0] b);
      logic [7:0] n;
      if (b inside {["0":"9"]}) begin
         n = b - "0";
      end else if (b inside {["A":"F"]}) begin
         n = b - "A" + 8'd10;
      end else begin
         n = b - "a" + 8'd10;
      end
      return n[3:0];
   endfunction

   function automatic logic [7:0] nibble_char(input logic [3:0] n);
      if (n < 4'd10) begin
         return "0" + {4'd0, n};
      end
      return "A" + {4'd0, n} - 8'd10;
   endfunction

   function automatic void take_fresh(input logic [7:0] b);
      if (b == pced_pkg::PCT_CHAR) begin
         held_count = pced_pkg::HELD_PCT;
      end else begin
         step_bytes.insert(step_bytes.size(), b);
      end
   endfunction

   function automatic void codec_step(input logic [7:0] b, input logic l);
      step_bytes.delete();
      if (codec_dir == pced_pkg::DIR_ENCODE) begin
         held_count = pced_pkg::HELD_NONE;
         if (url_safe(b)) begin
            step_bytes.insert(step_bytes.size(), b);
         end else begin
            step_bytes.insert(step_bytes.size(), pced_pkg::PCT_CHAR);
            step_bytes.insert(step_bytes.size(), nibble_char(b[7:4]));
            step_bytes.insert(step_bytes.size(), nibble_char(b[3:0]));
         end
      end else begin
         unique case (held_count)
            pced_pkg::HELD_NONE: begin
               take_fresh(b);
            end
            pced_pkg::HELD_PCT: begin
               if (hex_ok(b)) begin
                  held_digit = b;
                  held_count = pced_pkg::HELD_DIGIT;
               end else begin
                  step_bytes.insert(step_bytes.size(), pced_pkg::PCT_CHAR);
                  held_count = pced_pkg::HELD_NONE;
                  take_fresh(b);
               end
            end
            default: begin
               if (hex_ok(b)) begin
                  step_bytes.insert(step_bytes.size(), {hex_nibble(held_digit),
                                                        hex_nibble(b)});
                  held_count = pced_pkg::HELD_NONE;
               end else begin
                  step_bytes.insert(step_bytes.size(), pced_pkg::PCT_CHAR);
                  step_bytes.insert(step_bytes.size(), held_digit);
                  held_count = pced_pkg::HELD_NONE;
                  take_fresh(b);
               end
            end
         endcase
         if (l) begin
            if (held_count != pced_pkg::HELD_NONE && step_bytes.size() < 3) begin
               step_bytes.insert(step_bytes.size(), pced_pkg::PCT_CHAR);
            end
            if (held_count == pced_pkg::HELD_DIGIT && step_bytes.size() < 3) begin
               step_bytes.insert(step_bytes.size(), held_digit);
            end
            held_count = pced_pkg::HELD_NONE;
         end
      end
   endfunction

   function automatic stim_row_type req_row(input logic [7:0] b, input logic l);
      stim_row_type r;
      r = '0;
      r.kind = ROW_REQ;
      r.data = b;
      r.last = l;
      return r;
   endfunction

   function automatic stim_row_type known_row(input logic [7:0] b, input logic l,
                                              input logic [1:0] n, input logic [7:0] b0,
                                              input logic [7:0] b1, input logic [7:0] b2);
      stim_row_type r;
      r = req_row(b, l);
      r.known_n = n;
      r.known[0] = b0;
      r.known[1] = b1;
      r.known[2] = b2;
      return r;
   endfunction

   function automatic stim_row_type csr_row(input logic d);
      stim_row_type r;
      r = '0;
      r.kind = ROW_CSR;
      r.data = {7'd0, d};
      return r;
   endfunction

   function automatic logic [7:0] rand_hex_char();
      logic [3:0] n;
      n = 4'($urandom_range(15));
      if (n < 4'd10) begin
         return "0" + {4'd0, n};
      end else if ($urandom_range(1) == 1) begin
         return "a" + {4'd0, n} - 8'd10;
      end
      return "A" + {4'd0, n} - 8'd10;
   endfunction

   // Decoding needs escape-shaped input to get past the first held state, so
   // most fragments are escapes, whole or broken, and the rest is noise.
   function automatic void build_fragment(input logic d);
      int pick;
      pick = $urandom_range(99);
      if (d == pced_pkg::DIR_ENCODE || pick >= 70) begin
         fragment_q.insert(fragment_q.size(), 8'($urandom_range(255)));
      end else begin
         fragment_q.insert(fragment_q.size(), pced_pkg::PCT_CHAR);
         if (pick < 45) begin
            fragment_q.insert(fragment_q.size(), rand_hex_char());
            fragment_q.insert(fragment_q.size(), rand_hex_char());
         end else if (pick < 60) begin
            fragment_q.insert(fragment_q.size(), rand_hex_char());
            fragment_q.insert(fragment_q.size(), 8'($urandom_range(255)));
         end else begin
            fragment_q.insert(fragment_q.size(), 8'($urandom_range(255)));
         end
      end
   endfunction

   task automatic send_request(input logic [7:0] b, input logic l, input logic [1:0] known_n,
                               input logic [2:0][7:0] known);
      out_byte_type e;
      while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= l;
      @(posedge clock);
      while (!req_tready) begin
         @(posedge clock);
      end
      codec_step(b, l);
      if (known_n != 2'd0) begin
         step_bytes.delete();
         for (int k = 0; k < known_n; k++) begin
            step_bytes.insert(step_bytes.size(), known[k]);
         end
      end
      foreach (step_bytes[k]) begin
         e.data       = step_bytes[k];
         e.run_last   = (k == step_bytes.size() - 1);
         e.string_end = e.run_last && l;
         awaited_bytes.insert(awaited_bytes.size(), e);
      end
   endtask

   task automatic write_direction(input logic d);
      req_tvalid <= 1'b0;
      while (awaited_bytes.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= d;
      @(posedge clock);
      csr_wr_en  <= 1'b0;
      codec_dir  = d;
      held_count = pced_pkg::HELD_NONE;
   endtask

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (awaited_bytes.size() == 0) begin
            $error("result with no request pending: out_byte %0h", rsp_tdata);
            mismatch_count++;
         end else begin
            head = awaited_bytes.pop_front();
            if (rsp_tdata !== head.data) begin
               $error("out_byte: expected %0h, actual %0h", head.data, rsp_tdata);
               mismatch_count++;
            end
            if (rsp_tlast !== head.run_last) begin
               $error("run_last: expected %0b, actual %0b", head.run_last, rsp_tlast);
               mismatch_count++;
            end
            if (rsp_tuser !== head.string_end) begin
               $error("string_end: expected %0b, actual %0b", head.string_end, rsp_tuser);
               mismatch_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("FAILURE");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      int sent;
      logic [7:0] b;
      reset       <= 1'b1;
      csr_wr_en   <= 1'b0;
      csr_wr_data <= 1'b0;
      req_tvalid  <= 1'b0;
      req_tdata   <= '0;
      req_tlast   <= 1'b0;
      codec_dir   = pced_pkg::DIR_ENCODE;
      held_count  = pced_pkg::HELD_NONE;
      held_digit  = '0;

      // Encoding from reset, then decoding: escapes whole, broken and flushed.
      stim_rows.insert(stim_rows.size(), known_row("A", 1'b0, 2'd1, "A", 8'd0, 8'd0));
      stim_rows.insert(stim_rows.size(), known_row(8'h00, 1'b0, 2'd3, "%", "0", "0"));
      stim_rows.insert(stim_rows.size(), known_row(8'hFF, 1'b0, 2'd3, "%", "F", "F"));
      stim_rows.insert(stim_rows.size(), known_row("~", 1'b0, 2'd1, "~", 8'd0, 8'd0));
      stim_rows.insert(stim_rows.size(), req_row(8'h80, 1'b0));
      stim_rows.insert(stim_rows.size(), known_row(" ", 1'b1, 2'd3, "%", "2", "0"));
      stim_rows.insert(stim_rows.size(), csr_row(pced_pkg::DIR_DECODE));
      stim_rows.insert(stim_rows.size(), req_row("%", 1'b0));
      stim_rows.insert(stim_rows.size(), req_row("f", 1'b0));
      stim_rows.insert(stim_rows.size(), known_row("F", 1'b1, 2'd1, 8'hFF, 8'd0, 8'd0));
      stim_rows.insert(stim_rows.size(), req_row("%", 1'b0));
      stim_rows.insert(stim_rows.size(), req_row("9", 1'b0));
      stim_rows.insert(stim_rows.size(), req_row("z", 1'b0));
      stim_rows.insert(stim_rows.size(), req_row("%", 1'b0));
      stim_rows.insert(stim_rows.size(), req_row("%", 1'b0));
      stim_rows.insert(stim_rows.size(), req_row("G", 1'b0));
      stim_rows.insert(stim_rows.size(), req_row("%", 1'b0));
      stim_rows.insert(stim_rows.size(), known_row("0", 1'b1, 2'd2, "%", "0", 8'd0));
      stim_rows.insert(stim_rows.size(), known_row("%", 1'b1, 2'd1, "%", 8'd0, 8'd0));
      stim_rows.insert(stim_rows.size(), req_row("%", 1'b0));
      stim_rows.insert(stim_rows.size(), req_row("A", 1'b0));
      stim_rows.insert(stim_rows.size(), known_row("%", 1'b1, 2'd3, "%", "A", "%"));
      stim_rows.insert(stim_rows.size(), req_row("%", 1'b0));
      stim_rows.insert(stim_rows.size(), csr_row(pced_pkg::DIR_DECODE));
      stim_rows.insert(stim_rows.size(), known_row("7", 1'b1, 2'd1, "7", 8'd0, 8'd0));

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (stim_rows[i]) begin
         if (stim_rows[i].kind == ROW_CSR) begin
            write_direction(stim_rows[i].data[0]);
         end else begin
            send_request(stim_rows[i].data, stim_rows[i].last, stim_rows[i].known_n,
                         stim_rows[i].known);
         end
      end

      for (int p = 0; p < PHASES; p++) begin
         write_direction(PHASE_DIR[p]);
         send_idle_pct = PHASE_SEND_IDLE[p];
         rsp_stall_pct = PHASE_RSP_STALL[p];
         fragment_q.delete();
         sent = 0;
         while (sent < ITEMS_PER_PHASE) begin
            if (fragment_q.size() == 0) begin
               build_fragment(codec_dir);
            end
            b = fragment_q.pop_front();
            send_request(b, $urandom_range(7) == 0, 2'd0, '0);
            sent++;
            if (p == PRESSURE_PHASE && sent == ITEMS_PER_PHASE / 2) begin
               req_tvalid <= 1'b0;
               do begin
                  @(posedge clock);
               end while (awaited_bytes.size() != 0);
            end
         end
      end

      req_tvalid <= 1'b0;
      while (awaited_bytes.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && awaited_bytes.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

[percent_encode_decode_core.f]
rtl/pced_pkg.sv
rtl/pced_front.sv
rtl/pced_queue.sv
rtl/pced_back.sv
rtl/percent_encode_decode_core.sv
rtl/pced_checker.sv
tb/tb.sv
